/* rtl/core/min_turn_grid_path_assert.svh */
// Assertion macros shared by the minimum-bend grid path search RTL.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef MIN_TURN_GRID_PATH_ASSERT_SVH
`define MIN_TURN_GRID_PATH_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MTGP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define MTGP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/mtgp_pkg.sv */
// Package for the minimum-bend grid path search: sizes, codes and shared types.
// No dependencies; every module of the block imports it.
package mtgp_pkg;

    localparam int MaxCols   = 128;
    localparam int MaxRows   = 128;
    localparam int ColBits   = $clog2(MaxCols);
    localparam int RowBits   = $clog2(MaxRows);
    localparam int CellBits  = RowBits + ColBits;
    localparam int QueueBits = CellBits + 2;
    localparam int PtrBits   = QueueBits + 1;
    localparam int LevelBits = 14;
    localparam int CfgBits   = 8;
    localparam int AddrBits  = 3;
    localparam int FifoDepth = 4;
    localparam int FifoBits  = $clog2(FifoDepth);

    localparam logic [LevelBits-1:0] LevelMax = {LevelBits{1'b1}};

    localparam logic [1:0] KIND_OPEN     = 2'd0;
    localparam logic [1:0] KIND_WALL     = 2'd1;
    localparam logic [1:0] KIND_ENDPOINT = 2'd2;
    localparam logic [1:0] KIND_UNUSED   = 2'd3;

    localparam logic [1:0] STATUS_OK          = 2'd0;
    localparam logic [1:0] STATUS_UNREACHABLE = 2'd1;
    localparam logic [1:0] STATUS_NO_ENDS     = 2'd2;

    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_RIGHT = 2'd1;
    localparam logic [1:0] DIR_DOWN  = 2'd2;
    localparam logic [1:0] DIR_LEFT  = 2'd3;

    localparam logic [AddrBits-1:0] ADDR_WIDTH  = 3'd0;
    localparam logic [AddrBits-1:0] ADDR_HEIGHT = 3'd4;

    typedef struct packed {
        logic [CellBits-1:0] cell_idx;
        logic                wall;
        logic                endpoint;
        logic                last;
    } item_t;

    typedef struct packed {
        logic [CfgBits-1:0] width;
        logic [CfgBits-1:0] height;
    } grid_cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_CLEAR,
        ST_SEED,
        ST_SCAN,
        ST_S_POP,
        ST_S_NB,
        ST_TURN,
        ST_T_POP,
        ST_T_RD,
        ST_T_PUSH2,
        ST_EMIT
    } state_t;

endpackage

/* rtl/core/min_turn_grid_path.sv */
// Minimum-bend grid path search. Grid cells stream in one beat per cycle into a
// four-entry queue, so loading runs at one cell per clock while the engine keeps up.
// On the beat marked last the engine checks the endpoints and, unless they are missing,
// out of the area or the same cell, searches: it clears the 16384-entry direction store,
// seeds the source in all four directions, then alternates straight and turn sweeps over
// (cell, direction) states. One result beat follows; further cells wait in the queue
// meanwhile. Width and height are written over the APB port at byte addresses 0 and 4;
// the user must write them only while the block is idle, as the block does not enforce it.
// Depends on mtgp_pkg, mtgp_front, mtgp_search and min_turn_grid_path_assert.svh.
`include "min_turn_grid_path_assert.svh"

module min_turn_grid_path
    import mtgp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [AddrBits-1:0]  paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [RowBits-1:0]   row,
    input  logic [ColBits-1:0]   col,
    input  logic [1:0]           cell_kind,
    input  logic                 last,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [LevelBits-1:0] mirror_count,
    output logic [1:0]           status
);

    logic [CfgBits-1:0] width_reg, width_next;
    logic [CfgBits-1:0] height_reg, height_next;
    logic               cfg_write;
    logic               item_valid, item_ready;
    item_t              item;
    grid_cfg_t          cfg;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    // Only bit 2 of the address selects a register.
    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_write)
        begin
            if (paddr[2] == ADDR_HEIGHT[2])
                height_next = pwdata[CfgBits-1:0];
            else
                width_next = pwdata[CfgBits-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CfgBits'(MaxCols);
            height_reg <= CfgBits'(MaxRows);
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    assign prdata = {{(32-CfgBits){1'b0}},
                     (paddr[2] == ADDR_HEIGHT[2]) ? height_reg : width_reg};

    assign cfg.width  = width_reg;
    assign cfg.height = height_reg;

    mtgp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .row        (row),
        .col        (col),
        .cell_kind  (cell_kind),
        .last       (last),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item)
    );

    mtgp_search u_search (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .cfg          (cfg),
        .res_valid    (out_valid),
        .res_ready    (out_ready),
        .mirror_count (mirror_count),
        .status       (status)
    );

    `MTGP_ASSERT_IMP(a_status_code, out_valid, (status == STATUS_OK || status == STATUS_UNREACHABLE || status == STATUS_NO_ENDS), "result status is not a defined code")
    `MTGP_ASSERT_IMP(a_count_zero, out_valid && status != STATUS_OK, mirror_count == '0, "failed search reports a nonzero count")
    `MTGP_ASSERT_NEXT(a_width_write, cfg_write && paddr[2] == ADDR_WIDTH[2], width_reg == $past(pwdata[CfgBits-1:0]), "width register missed a write")
    `MTGP_ASSERT_NEXT(a_height_write, cfg_write && paddr[2] == ADDR_HEIGHT[2], height_reg == $past(pwdata[CfgBits-1:0]), "height register missed a write")

endmodule

/* rtl/core/mtgp_front.sv */
// Front end: takes input beats, classifies each cell and queues it for the search engine.
// Depends on mtgp_pkg.
module mtgp_front
    import mtgp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [RowBits-1:0]  row,
    input  logic [ColBits-1:0]  col,
    input  logic [1:0]          cell_kind,
    input  logic                last,
    output logic                item_valid,
    input  logic                item_ready,
    output item_t               item
);

    item_t               fifo_mem [FifoDepth];
    logic [FifoBits-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FifoBits-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FifoBits:0]   count_reg, count_next;
    logic                push, pop;
    item_t               new_item;

    assign in_ready   = (count_reg != (FifoBits+1)'(FifoDepth));
    assign item_valid = (count_reg != '0);
    assign item       = fifo_mem[rd_ptr_reg];
    assign push       = in_valid && in_ready;
    assign pop        = item_valid && item_ready;

    // The row lands in the upper bits of the cell index since MaxCols is a power of two.
    always_comb
    begin
        new_item.cell_idx = {row, col};
        new_item.wall     = (cell_kind == KIND_WALL);
        new_item.endpoint = (cell_kind == KIND_ENDPOINT);
        new_item.last     = last;
    end

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (FifoBits+1)'(push) - (FifoBits+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[wr_ptr_reg] <= new_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* rtl/core/mtgp_search.sv */
// Back end: stores the grid, runs the level-by-level bend search and holds the result beat.
// Depends on mtgp_pkg.
module mtgp_search
    import mtgp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  item_t                item,
    input  grid_cfg_t            cfg,
    output logic                 res_valid,
    input  logic                 res_ready,
    output logic [LevelBits-1:0] mirror_count,
    output logic [1:0]           status
);

    logic                wall_mem  [MaxRows*MaxCols];
    logic [3:0]          reach_mem [MaxRows*MaxCols];
    logic [QueueBits-1:0] queue_mem [4*MaxRows*MaxCols];

    state_t state_reg, state_next;

    logic [CellBits-1:0]  src_reg, src_next, tgt_reg, tgt_next;
    logic [1:0]           ep_reg, ep_next;
    logic [PtrBits-1:0]   lo_reg, lo_next, hi_reg, hi_next;
    logic [PtrBits-1:0]   idx_reg, idx_next, tend_reg, tend_next;
    logic [LevelBits-1:0] level_reg, level_next;
    logic [CellBits-1:0]  clr_reg, clr_next;
    logic [1:0]           seed_reg, seed_next;
    logic [CellBits-1:0]  cur_cell_reg, cur_cell_next, nb_reg, nb_next;
    logic [1:0]           cur_dir_reg, cur_dir_next, pend_dir_reg, pend_dir_next;
    logic [1:0]           rstat_reg, rstat_next;
    logic [LevelBits-1:0] rcount_reg, rcount_next;
    logic                 out_valid_reg, out_valid_next;
    logic [LevelBits-1:0] out_count_reg, out_count_next;
    logic [1:0]           out_status_reg, out_status_next;

    logic                 wall_we, wall_wdata, wall_rdata_reg;
    logic [CellBits-1:0]  wall_waddr, wall_raddr;
    logic                 reach_we;
    logic [3:0]           reach_wdata, reach_rdata_reg;
    logic [CellBits-1:0]  reach_waddr, reach_raddr;
    logic                 q_we;
    logic [QueueBits-1:0] q_wdata, q_rdata_reg;

    logic [CfgBits-1:0]   w_eff, h_eff;
    logic                 area_bad, no_ends, trivial;
    logic [CellBits-1:0]  pop_cell;
    logic [1:0]           pop_dir;
    logic [RowBits-1:0]   pop_row, nb_row;
    logic [ColBits-1:0]   pop_col, nb_col;
    logic                 oob, hit_target, nb_open;
    logic [1:0]           nd_a, nd_b;
    logic                 push_a, push_b;
    logic                 emit_go, scan_done, turn_done;

    assign w_eff = (cfg.width  > CfgBits'(MaxCols)) ? CfgBits'(MaxCols) : cfg.width;
    assign h_eff = (cfg.height > CfgBits'(MaxRows)) ? CfgBits'(MaxRows) : cfg.height;

    assign no_ends  = (ep_reg < 2'd2);
    assign area_bad = (CfgBits'(src_reg[CellBits-1:ColBits]) >= h_eff)
                   || (CfgBits'(src_reg[ColBits-1:0]) >= w_eff)
                   || (CfgBits'(tgt_reg[CellBits-1:ColBits]) >= h_eff)
                   || (CfgBits'(tgt_reg[ColBits-1:0]) >= w_eff);
    assign trivial  = (src_reg == tgt_reg);

    assign pop_cell   = q_rdata_reg[QueueBits-1:2];
    assign pop_dir    = q_rdata_reg[1:0];
    assign pop_row    = pop_cell[CellBits-1:ColBits];
    assign pop_col    = pop_cell[ColBits-1:0];
    assign hit_target = (pop_cell == tgt_reg);

    always_comb
    begin
        nb_row = pop_row;
        nb_col = pop_col;
        oob    = 1'b0;
        case (pop_dir)
            DIR_UP:
            begin
                nb_row = pop_row - 1'b1;
                oob    = (pop_row == '0);
            end
            DIR_RIGHT:
            begin
                nb_col = pop_col + 1'b1;
                oob    = (CfgBits'(pop_col) + 1'b1 >= w_eff);
            end
            DIR_DOWN:
            begin
                nb_row = pop_row + 1'b1;
                oob    = (CfgBits'(pop_row) + 1'b1 >= h_eff);
            end
            default:
            begin
                nb_col = pop_col - 1'b1;
                oob    = (pop_col == '0);
            end
        endcase
    end

    assign nb_open   = !wall_rdata_reg && !reach_rdata_reg[cur_dir_reg];
    assign nd_a      = cur_dir_reg + 2'd1;
    assign nd_b      = cur_dir_reg + 2'd3;
    assign push_a    = !reach_rdata_reg[nd_a];
    assign push_b    = !reach_rdata_reg[nd_b];
    assign emit_go   = !out_valid_reg || res_ready;
    assign scan_done = (idx_reg == hi_reg);
    assign turn_done = (idx_reg == tend_reg);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    if (item_valid && item.last) state_next = ST_CHECK;
            ST_CHECK:   state_next = (no_ends || area_bad || trivial) ? ST_EMIT : ST_CLEAR;
            ST_CLEAR:   if (clr_reg == {CellBits{1'b1}}) state_next = ST_SEED;
            ST_SEED:    if (seed_reg == 2'd3) state_next = ST_SCAN;
            ST_SCAN:    state_next = scan_done ? ST_TURN : ST_S_POP;
            ST_S_POP:
            begin
                if (hit_target)
                    state_next = ST_EMIT;
                else if (oob)
                    state_next = ST_SCAN;
                else
                    state_next = ST_S_NB;
            end
            ST_S_NB:    state_next = ST_SCAN;
            ST_TURN:
            begin
                if (!turn_done)
                    state_next = ST_T_POP;
                else if (hi_reg == tend_reg)
                    state_next = ST_EMIT;
                else
                    state_next = ST_SCAN;
            end
            ST_T_POP:   state_next = ST_T_RD;
            ST_T_RD:    state_next = (push_a && push_b) ? ST_T_PUSH2 : ST_TURN;
            ST_T_PUSH2: state_next = ST_TURN;
            ST_EMIT:    if (emit_go) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // Datapath and memory controls.
    always_comb
    begin
        src_next        = src_reg;
        tgt_next        = tgt_reg;
        ep_next         = ep_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        idx_next        = idx_reg;
        tend_next       = tend_reg;
        level_next      = level_reg;
        clr_next        = clr_reg;
        seed_next       = seed_reg;
        cur_cell_next   = cur_cell_reg;
        cur_dir_next    = cur_dir_reg;
        nb_next         = nb_reg;
        pend_dir_next   = pend_dir_reg;
        rstat_next      = rstat_reg;
        rcount_next     = rcount_reg;
        out_valid_next  = out_valid_reg && !res_ready;
        out_count_next  = out_count_reg;
        out_status_next = out_status_reg;
        item_ready      = 1'b0;
        wall_we         = 1'b0;
        wall_waddr      = item.cell_idx;
        wall_wdata      = item.wall;
        wall_raddr      = {nb_row, nb_col};
        reach_we        = 1'b0;
        reach_waddr     = cur_cell_reg;
        reach_wdata     = '0;
        reach_raddr     = {nb_row, nb_col};
        q_we            = 1'b0;
        q_wdata         = {cur_cell_reg, cur_dir_reg};

        unique case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    wall_we = 1'b1;
                    if (item.endpoint && ep_reg < 2'd2)
                    begin
                        if (ep_reg == 2'd0)
                            src_next = item.cell_idx;
                        else
                            tgt_next = item.cell_idx;
                        ep_next = ep_reg + 1'b1;
                    end
                end
            end
            ST_CHECK:
            begin
                ep_next     = '0;
                rcount_next = '0;
                hi_next     = '0;
                clr_next    = '0;
                seed_next   = '0;
                if (no_ends)
                    rstat_next = STATUS_NO_ENDS;
                else if (area_bad)
                    rstat_next = STATUS_UNREACHABLE;
                else
                    rstat_next = STATUS_OK;
            end
            ST_CLEAR:
            begin
                reach_we    = 1'b1;
                reach_waddr = clr_reg;
                clr_next    = clr_reg + 1'b1;
            end
            ST_SEED:
            begin
                reach_we    = 1'b1;
                reach_waddr = src_reg;
                reach_wdata = 4'hF;
                q_we        = 1'b1;
                q_wdata     = {src_reg, seed_reg};
                hi_next     = hi_reg + 1'b1;
                seed_next   = seed_reg + 1'b1;
                lo_next     = '0;
                idx_next    = '0;
                level_next  = '0;
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    idx_next  = lo_reg;
                    tend_next = hi_reg;
                end
            end
            ST_S_POP:
            begin
                cur_dir_next = pop_dir;
                nb_next      = {nb_row, nb_col};
                if (hit_target)
                begin
                    rstat_next  = STATUS_OK;
                    rcount_next = level_reg;
                end
                else if (oob)
                    idx_next = idx_reg + 1'b1;
            end
            ST_S_NB:
            begin
                idx_next = idx_reg + 1'b1;
                if (nb_open)
                begin
                    reach_we    = 1'b1;
                    reach_waddr = nb_reg;
                    reach_wdata = reach_rdata_reg | (4'b0001 << cur_dir_reg);
                    q_we        = 1'b1;
                    q_wdata     = {nb_reg, cur_dir_reg};
                    hi_next     = hi_reg + 1'b1;
                end
            end
            ST_TURN:
            begin
                if (turn_done)
                begin
                    lo_next  = tend_reg;
                    idx_next = tend_reg;
                    if (level_reg != LevelMax)
                        level_next = level_reg + 1'b1;
                    if (hi_reg == tend_reg)
                    begin
                        rstat_next  = STATUS_UNREACHABLE;
                        rcount_next = '0;
                    end
                end
            end
            ST_T_POP:
            begin
                cur_cell_next = pop_cell;
                cur_dir_next  = pop_dir;
                reach_raddr   = pop_cell;
            end
            ST_T_RD:
            begin
                idx_next      = idx_reg + 1'b1;
                reach_we      = 1'b1;
                reach_waddr   = cur_cell_reg;
                reach_wdata   = reach_rdata_reg | (4'b0001 << nd_a) | (4'b0001 << nd_b);
                pend_dir_next = nd_b;
                if (push_a || push_b)
                begin
                    q_we    = 1'b1;
                    q_wdata = {cur_cell_reg, push_a ? nd_a : nd_b};
                    hi_next = hi_reg + 1'b1;
                end
            end
            ST_T_PUSH2:
            begin
                q_we    = 1'b1;
                q_wdata = {cur_cell_reg, pend_dir_reg};
                hi_next = hi_reg + 1'b1;
            end
            ST_EMIT:
            begin
                if (emit_go)
                begin
                    out_valid_next  = 1'b1;
                    out_count_next  = rcount_reg;
                    out_status_next = rstat_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wall_we)
            wall_mem[wall_waddr] <= wall_wdata;
        wall_rdata_reg <= wall_mem[wall_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (reach_we)
            reach_mem[reach_waddr] <= reach_wdata;
        reach_rdata_reg <= reach_mem[reach_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (q_we)
            queue_mem[hi_reg[QueueBits-1:0]] <= q_wdata;
        q_rdata_reg <= queue_mem[idx_reg[QueueBits-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            src_reg       <= '0;
            tgt_reg       <= '0;
            ep_reg        <= '0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            idx_reg       <= '0;
            tend_reg      <= '0;
            level_reg     <= '0;
            clr_reg       <= '0;
            seed_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            src_reg       <= src_next;
            tgt_reg       <= tgt_next;
            ep_reg        <= ep_next;
            lo_reg        <= lo_next;
            hi_reg        <= hi_next;
            idx_reg       <= idx_next;
            tend_reg      <= tend_next;
            level_reg     <= level_next;
            clr_reg       <= clr_next;
            seed_reg      <= seed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Straight-phase pops need the popped cell kept as the current cell too.
    always_ff @(posedge clk)
    begin
        cur_cell_reg   <= (state_reg == ST_S_POP) ? pop_cell : cur_cell_next;
        cur_dir_reg    <= cur_dir_next;
        nb_reg         <= nb_next;
        pend_dir_reg   <= pend_dir_next;
        rstat_reg      <= rstat_next;
        rcount_reg     <= rcount_next;
        out_count_reg  <= out_count_next;
        out_status_reg <= out_status_next;
    end

    assign res_valid    = out_valid_reg;
    assign mirror_count = out_count_reg;
    assign status       = out_status_reg;

endmodule

/* dv/testbench.sv */
// Testbench for min_turn_grid_path: streams grids cell by cell, predicts the fewest turns
// with a level-by-level search over (cell, direction) states, and checks each result beat.
// Depends on mtgp_pkg and the min_turn_grid_path RTL.
`timescale 1ns / 100ps

import mtgp_pkg::*;

class path_scoreboard;
    typedef struct {
        logic [LevelBits-1:0] turns;
        logic [1:0]           code;
    } path_result_t;

    logic [CfgBits-1:0] width_reg = 8'd128;
    logic [CfgBits-1:0] height_reg = 8'd128;
    bit                 wall_at[MaxRows*MaxCols];
    bit [3:0]           seen_dir[MaxRows*MaxCols];
    int unsigned        sweep[4*MaxRows*MaxCols];
    int unsigned        src_idx;
    int unsigned        dst_idx;
    int unsigned        ends_seen;
    path_result_t       pending[$];
    int                 errors;

    function bit mark(int unsigned idx, int unsigned d);
        if (seen_dir[idx][d])
            return 0;
        seen_dir[idx][d] = 1'b1;
        return 1;
    endfunction

    function void run_search(output logic [1:0] code, output logic [LevelBits-1:0] turns);
        int          step_r[4];
        int          step_c[4];
        int unsigned w, h, lo, hi, nxt, i, c, d, nd, level;
        int          nr, nc;
        step_r = '{-1, 0, 1, 0};
        step_c = '{0, 1, 0, -1};
        w = (width_reg > MaxCols) ? MaxCols : width_reg;
        h = (height_reg > MaxRows) ? MaxRows : height_reg;
        turns = '0;
        code = STATUS_UNREACHABLE;
        if (src_idx / MaxCols >= h || src_idx % MaxCols >= w ||
            dst_idx / MaxCols >= h || dst_idx % MaxCols >= w)
            return;
        if (src_idx == dst_idx)
        begin
            code = STATUS_OK;
            return;
        end
        foreach (seen_dir[k])
            seen_dir[k] = '0;
        level = 0;
        hi = 0;
        for (d = 0; d < 4; d++)
        begin
            void'(mark(src_idx, d));
            sweep[hi++] = (src_idx << 2) | d;
        end
        lo = 0;
        while (lo < hi)
        begin
            // Straight moves at this level cost nothing, so they extend the same level.
            i = lo;
            while (i < hi)
            begin
                c = sweep[i] >> 2;
                d = sweep[i] & 3;
                i++;
                if (c == dst_idx)
                begin
                    code = STATUS_OK;
                    turns = LevelBits'(level);
                    return;
                end
                nr = int'(c / MaxCols) + step_r[d];
                nc = int'(c % MaxCols) + step_c[d];
                if (nr < 0 || nc < 0 || nr >= int'(h) || nc >= int'(w))
                    continue;
                if (wall_at[nr * MaxCols + nc])
                    continue;
                if (mark(nr * MaxCols + nc, d))
                    sweep[hi++] = ((nr * MaxCols + nc) << 2) | d;
            end
            nxt = hi;
            for (i = lo; i < hi; i++)
            begin
                c = sweep[i] >> 2;
                d = sweep[i] & 3;
                nd = (d + 1) & 3;
                if (mark(c, nd))
                    sweep[nxt++] = (c << 2) | nd;
                nd = (d + 3) & 3;
                if (mark(c, nd))
                    sweep[nxt++] = (c << 2) | nd;
            end
            lo = hi;
            hi = nxt;
            if (level < LevelMax)
                level++;
        end
    endfunction

    function void note_cell(logic [RowBits-1:0] r, logic [ColBits-1:0] c,
                            logic [1:0] kind, logic is_last);
        int unsigned  idx;
        path_result_t res;
        idx = r * MaxCols + c;
        wall_at[idx] = (kind == KIND_WALL);
        if (kind == KIND_ENDPOINT)
        begin
            if (ends_seen == 0)
                src_idx = idx;
            else if (ends_seen == 1)
                dst_idx = idx;
            if (ends_seen < 2)
                ends_seen++;
        end
        if (!is_last)
            return;
        if (ends_seen < 2)
        begin
            res.code = STATUS_NO_ENDS;
            res.turns = '0;
        end
        else
            run_search(res.code, res.turns);
        ends_seen = 0;
        pending = {pending, res};
    endfunction

    function void check_result(logic [LevelBits-1:0] turns, logic [1:0] code);
        path_result_t exp_res;
        if (pending.size() == 0)
        begin
            $error("result beat with nothing expected: mirror_count %0d status %0d",
                   turns, code);
            errors++;
            return;
        end
        exp_res = pending.pop_front();
        if (turns !== exp_res.turns)
        begin
            $error("mirror_count expected %0d actual %0d", exp_res.turns, turns);
            errors++;
        end
        if (code !== exp_res.code)
        begin
            $error("status expected %0d actual %0d", exp_res.code, code);
            errors++;
        end
    endfunction
endclass

module testbench;
    localparam int ItemTarget = 1000;
    localparam int QuietFrom  = 850;
    localparam int CycleLimit = 20000000;

    typedef struct {
        logic [RowBits-1:0] r;
        logic [ColBits-1:0] c;
        logic [1:0]         kind;
    } cell_beat_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [AddrBits-1:0]  paddr = '0;
    logic [31:0]          pwdata = '0;
    logic [31:0]          prdata;
    logic                 pready;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [RowBits-1:0]   row = '0;
    logic [ColBits-1:0]   col = '0;
    logic [1:0]           cell_kind = '0;
    logic                 last = 1'b0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [LevelBits-1:0] mirror_count;
    logic [1:0]           status;

    path_scoreboard grid_sb = new();
    int             cells_sent;
    bit             quiet;
    int             stall_left;
    longint         cycle_count;

    min_turn_grid_path DUT (.*);

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CycleLimit)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
            grid_sb.check_result(mirror_count, status);

    // Receiver stalls come in bursts; no new burst starts once the run is in its quiet tail.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(1, 17) - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    task automatic reg_write(input logic [AddrBits-1:0] addr, input logic [7:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= {24'd0, value};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (addr == ADDR_WIDTH)
            grid_sb.width_reg = value;
        else
            grid_sb.height_reg = value;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic send_cell(input cell_beat_t b, input logic is_last);
        if (!quiet && $urandom_range(0, 9) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        in_valid <= 1'b1;
        row <= b.r;
        col <= b.c;
        cell_kind <= b.kind;
        last <= is_last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        grid_sb.note_cell(b.r, b.c, b.kind, is_last);
        cells_sent++;
        @(negedge clk);
    endtask

    task automatic send_list(input cell_beat_t beats[$]);
        foreach (beats[k])
            send_cell(beats[k], k == beats.size() - 1);
    endtask

    // Called at a falling edge; the search may still run for a full clearing pass.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (grid_sb.pending.size() != 0)
            @(negedge clk);
        repeat (50) @(negedge clk);
    endtask

    task automatic set_size(input logic [7:0] w, input logic [7:0] h);
        wait_drained();
        reg_write(ADDR_WIDTH, w);
        reg_write(ADDR_HEIGHT, h);
    endtask

    // One grid covering the whole configured area, with a random twist on the endpoints.
    task automatic load_grid();
        cell_beat_t  beats[$];
        cell_beat_t  b;
        int unsigned w, h, s, t, wall_pct, twist, k;
        w = (grid_sb.width_reg > MaxCols) ? MaxCols : grid_sb.width_reg;
        h = (grid_sb.height_reg > MaxRows) ? MaxRows : grid_sb.height_reg;
        if (w == 0 || h == 0)
        begin
            // Nothing is searched here, so the endpoints may sit on any cell.
            b.r = RowBits'($urandom); b.c = ColBits'($urandom); b.kind = KIND_ENDPOINT;
            beats = {beats, b};
            b.r = RowBits'($urandom); b.c = ColBits'($urandom);
            beats = {beats, b};
            send_list(beats);
            return;
        end
        wall_pct = $urandom_range(0, 45);
        twist = $urandom_range(0, 11);
        s = $urandom_range(0, w * h - 1);
        t = $urandom_range(0, w * h - 1);
        for (k = 0; k < w * h; k++)
        begin
            b.r = RowBits'(k / w);
            b.c = ColBits'(k % w);
            if ((k == s && twist != 0) || (k == t && twist > 1 && twist != 5))
                b.kind = KIND_ENDPOINT;
            else if ($urandom_range(0, 99) < wall_pct)
                b.kind = KIND_WALL;
            else
                b.kind = ($urandom_range(0, 7) == 0) ? KIND_UNUSED : KIND_OPEN;
            beats = {beats, b};
        end
        b.kind = KIND_ENDPOINT;
        case (twist)
            3:
            begin
                // A third endpoint only counts as an open cell.
                b.r = RowBits'($urandom_range(0, h - 1));
                b.c = ColBits'($urandom_range(0, w - 1));
                beats = {beats, b};
            end
            4:
            begin
                b.r = RowBits'(s / w); b.c = ColBits'(s % w); b.kind = KIND_WALL;
                beats = {beats, b};
            end
            5:
            begin
                b.r = RowBits'(s / w); b.c = ColBits'(s % w);
                beats = {beats, b};
            end
            6:
            begin
                b.r = RowBits'(t / w); b.c = ColBits'(t % w); b.kind = KIND_WALL;
                beats = {beats, b};
            end
            default: ;
        endcase
        send_list(beats);
    endtask

    task automatic directed_cells();
        cell_beat_t beats[$];
        beats = '{'{7'd0, 7'd0, KIND_ENDPOINT}, '{7'd0, 7'd1, KIND_WALL},
                  '{7'd0, 7'd2, KIND_OPEN}, '{7'd1, 7'd0, KIND_OPEN},
                  '{7'd1, 7'd1, KIND_WALL}, '{7'd1, 7'd2, KIND_UNUSED},
                  '{7'd2, 7'd0, KIND_OPEN}, '{7'd2, 7'd1, KIND_OPEN},
                  '{7'd2, 7'd2, KIND_ENDPOINT}};
        send_list(beats);
        beats = '{'{7'd0, 7'd0, KIND_OPEN}};
        send_list(beats);
        beats = '{'{7'd0, 7'd0, KIND_ENDPOINT}, '{7'd0, 7'd0, KIND_ENDPOINT}};
        send_list(beats);
        beats = '{'{7'd127, 7'd127, KIND_UNUSED}, '{7'd127, 7'd0, KIND_WALL},
                  '{7'd0, 7'd127, KIND_ENDPOINT}, '{7'd2, 7'd2, KIND_OPEN}};
        send_list(beats);
        // Wall between two endpoints on a 3x1 strip: the target is cut off.
        set_size(8'd3, 8'd1);
        beats = '{'{7'd0, 7'd0, KIND_ENDPOINT}, '{7'd0, 7'd1, KIND_WALL},
                  '{7'd0, 7'd2, KIND_ENDPOINT}};
        send_list(beats);
    endtask

    initial
    begin
        logic [7:0] w, h;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        set_size(8'd3, 8'd3);
        directed_cells();
        set_size(8'd255, 8'd1);
        load_grid();
        set_size(8'd1, 8'd255);
        load_grid();
        set_size(8'd0, 8'd5);
        load_grid();
        set_size(8'd5, 8'd0);
        load_grid();
        while (cells_sent < ItemTarget)
        begin
            // Large grids only while they still fit in the item budget.
            if ($urandom_range(0, 7) == 0 && cells_sent + 1024 <= ItemTarget)
            begin
                w = 8'($urandom_range(12, 32));
                h = 8'($urandom_range(12, 32));
            end
            else
            begin
                w = 8'($urandom_range(1, 10));
                h = 8'($urandom_range(1, 10));
            end
            set_size(w, h);
            repeat ($urandom_range(1, 3))
            begin
                quiet = (cells_sent >= QuietFrom);
                if (cells_sent + int'(w) * int'(h) <= ItemTarget + 100)
                    load_grid();
            end
        end
        wait_drained();
        if (grid_sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

/* min_turn_grid_path.f */
+incdir+rtl/core
rtl/core/mtgp_pkg.sv
rtl/core/mtgp_front.sv
rtl/core/mtgp_search.sv
rtl/core/min_turn_grid_path.sv
dv/testbench.sv
